// ===== src/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned FRAC_BITS = 8;
  // quotient bits produced by the divider, one per stage
  localparam int unsigned QW = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_COMPARE  = 4'd4,
    CMD_MIN      = 4'd5,
    CMD_MAX      = 4'd6,
    CMD_FROM_INT = 4'd7,
    CMD_TO_INT   = 4'd8
  } fpa_cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] a_raw;
    logic signed [31:0] b_raw;
  } fpa_req_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               less;
    logic               equal;
    logic               greater;
    logic [1:0]         status;
  } fpa_rsp_t;

  // state carried down the pipeline with each request
  typedef struct packed {
    logic          is_mul;
    logic          arith;    // result comes from the mul/div saturation path
    logic          neg;      // sign of the mul/div result
    logic [31:0]   quick;    // result of the operations computed in the decode stage
    logic [1:0]    status;
    logic          less;
    logic          equal;
    logic          greater;
    logic [63:0]   prod;
    logic [31:0]   den;
    logic [32:0]   rem;
    logic [QW-1:0] nq;       // numerator bits in, quotient bits out
  } fpa_pipe_t;

endpackage

// ===== src/fixed_point_alu.sv =====
// Fixed-point ALU top: decode stage, multiply stage, QW divider stages, output stage.
// Every command passes through all stages; one request per cycle, busy never set.
// The divider chain (one quotient bit per stage) sets the latency.
// Reset clears all valid bits; results are not held, done_o strobes for one cycle.
// Depends on fpa_pkg, fpa_mul_stage, fpa_div_stage.
`timescale 1ns / 1ps
module fixed_point_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fpa_pkg::fpa_req_t req_i,
  output logic             done_o,
  output fpa_pkg::fpa_rsp_t rsp_o
);
  import fpa_pkg::*;

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  fpa_pipe_t  dec_d, dec_q;
  logic       dec_vq;
  logic [31:0] mag_a, mag_b;
  logic        a_neg, b_neg;

  fpa_pipe_t chain_p [QW+1];
  logic      chain_v [QW+1];

  logic [QW:0]  qq;
  logic [63:0]  mm, m;
  logic [31:0]  res;
  logic [1:0]   st;
  fpa_rsp_t     rsp_d, rsp_q;
  logic         done_q;

  assign busy = 1'b0;

  always_comb begin
    a_neg = req_i.a_raw[31];
    b_neg = req_i.b_raw[31];
    mag_a = a_neg ? 32'(-req_i.a_raw) : req_i.a_raw;
    mag_b = b_neg ? 32'(-req_i.b_raw) : req_i.b_raw;
    dec_d = '0;
    dec_d.less    = req_i.a_raw < req_i.b_raw;
    dec_d.equal   = req_i.a_raw == req_i.b_raw;
    dec_d.greater = req_i.a_raw > req_i.b_raw;
    dec_d.neg     = a_neg ^ b_neg;
    dec_d.den     = mag_b;
    dec_d.nq      = {mag_a, {FRAC_BITS{1'b0}}};
    dec_d.is_mul  = req_i.cmd == CMD_MUL;
    unique case (req_i.cmd)
      CMD_ADD:      dec_d.quick = req_i.a_raw + req_i.b_raw;
      CMD_SUB:      dec_d.quick = req_i.a_raw - req_i.b_raw;
      CMD_MUL:      dec_d.arith = 1'b1;
      CMD_DIV: begin
        if (req_i.b_raw == 32'sd0) begin
          dec_d.status = ST_DIV0;
          dec_d.quick  = a_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          dec_d.arith = 1'b1;
        end
      end
      CMD_MIN:      dec_d.quick = dec_d.less ? req_i.a_raw : req_i.b_raw;
      CMD_MAX:      dec_d.quick = dec_d.greater ? req_i.a_raw : req_i.b_raw;
      CMD_FROM_INT: dec_d.quick = req_i.a_raw << FRAC_BITS;
      CMD_TO_INT: begin
        dec_d.quick = a_neg ? 32'(-(mag_a >> FRAC_BITS)) : (mag_a >> FRAC_BITS);
      end
      default:      dec_d.quick = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vq <= 1'b0;
    end else begin
      dec_vq <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
  end

  fpa_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_vq),
    .pipe_i  (dec_q),
    .valid_o (chain_v[0]),
    .pipe_o  (chain_p[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[i]),
      .pipe_i  (chain_p[i]),
      .valid_o (chain_v[i+1]),
      .pipe_o  (chain_p[i+1])
    );
  end

  // round half away from zero on magnitudes, then saturate
  always_comb begin
    qq = {1'b0, chain_p[QW].nq} +
         (QW+1)'({chain_p[QW].rem[31:0], 1'b0} >= {1'b0, chain_p[QW].den});
    mm = (chain_p[QW].prod + HALF) >> FRAC_BITS;
    m  = chain_p[QW].is_mul ? mm : 64'(qq);
    st = ST_OK;
    if (chain_p[QW].neg) begin
      if (m > 64'h8000_0000) begin
        st  = ST_SAT;
        res = 32'h8000_0000;
      end else begin
        res = 32'(-m[31:0]);
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        st  = ST_SAT;
        res = 32'h7FFF_FFFF;
      end else begin
        res = m[31:0];
      end
    end
    rsp_d.result_raw = chain_p[QW].arith ? res : chain_p[QW].quick;
    rsp_d.status     = chain_p[QW].arith ? st : chain_p[QW].status;
    rsp_d.less       = chain_p[QW].less;
    rsp_d.equal      = chain_p[QW].equal;
    rsp_d.greater    = chain_p[QW].greater;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule

// ===== src/fpa_div_stage.sv =====
// One restoring-division step: one quotient bit per stage, registered.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fpa_pkg::fpa_pipe_t pipe_i,
  output logic              valid_o,
  output fpa_pkg::fpa_pipe_t pipe_o
);
  import fpa_pkg::*;

  logic       valid_q;
  fpa_pipe_t  pipe_d, pipe_q;
  logic [32:0] rem_w;
  logic        take;

  always_comb begin
    rem_w  = {pipe_i.rem[31:0], pipe_i.nq[QW-1]};
    take   = rem_w >= {1'b0, pipe_i.den};
    pipe_d = pipe_i;
    pipe_d.rem = take ? rem_w - {1'b0, pipe_i.den} : rem_w;
    pipe_d.nq  = {pipe_i.nq[QW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;
endmodule

// ===== src/fpa_mul_stage.sv =====
// Magnitude multiply stage: 32x32 unsigned product, registered.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_mul_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fpa_pkg::fpa_pipe_t pipe_i,
  output logic              valid_o,
  output fpa_pkg::fpa_pipe_t pipe_o
);
  import fpa_pkg::*;

  logic      valid_q;
  fpa_pipe_t pipe_d, pipe_q;

  always_comb begin
    pipe_d = pipe_i;
    // magnitude of a sits in the top of the numerator field
    pipe_d.prod = pipe_i.nq[QW-1:FRAC_BITS] * pipe_i.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;
endmodule
